FILE: hw/rtl/mlfq_pkg.sv
// Package with the types and constants of the multilevel feedback scheduler.
`default_nettype none
package mlfq_pkg;
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_ADMIT = 1'b1;

  localparam logic [1:0] OUT_CONT  = 2'd0;
  localparam logic [1:0] OUT_FIN   = 2'd1;
  localparam logic [1:0] OUT_BLOCK = 2'd2;

  localparam logic [1:0] REG_Q0 = 2'd0;
  localparam logic [1:0] REG_Q1 = 2'd1;
  localparam logic [1:0] REG_IO = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_PICK,
    ST_READ,
    ST_EXEC,
    ST_PUSH,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/multilevel_feedback_scheduler_unit.sv
// Top level of the two-level feedback scheduler over process ids.
//
// Usage: raise start with command, proc_id, priority_req and outcome while
// busy is low. An admit puts proc_id at the level-0 tail and records its
// priority; a tick first ages the blocked list, returns expired entries to
// level 0, then runs one process, if any, and applies the outcome. Exactly one
// result follows each item: done is high for one cycle and the ran_* and
// admit_refused ports carry the result during that cycle.
// Sequence: an admit goes from idle to its result state. A tick walks the
// blocked list in a pipelined read-modify-write pass, then picks from level
// 0, or else from level 1, passing over empty groups from the highest down,
// then reads, executes and pushes the process before its result. Busy
// drops in the result cycle, so the next item may be taken at the edge that
// ends it.
// Configuration: cfg_we, cfg_index and cfg_data write quantum_level0,
// quantum_level1 and io_delay; write them only while busy is low.
// Reset: rst clears all queue counts and the configuration to 2, 4 and 3;
// the memories are not cleared, every read entry was written earlier.
// The receiver cannot stall: done marks each result for one cycle only.
`default_nettype none
module multilevel_feedback_scheduler_unit
  import mlfq_pkg::*;
#(
  parameter int MAX_PROCS = 16,
  parameter int PRIORITY_LEVELS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       command,
  input  wire logic [3:0] proc_id,
  input  wire logic [2:0] priority_req,
  input  wire logic [1:0] outcome,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_data,
  output logic            done,
  output logic            ran_valid,
  output logic [3:0]      ran_id,
  output logic            ran_finished,
  output logic            ran_blocked,
  output logic            ran_demoted,
  output logic            admit_refused
);
  localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int GW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int L1D = PRIORITY_LEVELS * MAX_PROCS;
  localparam int L1W = $clog2(L1D);
  localparam logic [CW-1:0] FULL = CW'(MAX_PROCS);
  localparam logic [GW-1:0] GMAX = GW'(PRIORITY_LEVELS - 1);

  // Configuration registers.
  logic [3:0] q0, q1, iod;
  logic [3:0] q0_eff, q1_eff, iod_eff;
  assign q0_eff  = (q0 == 4'd0) ? 4'd1 : q0;
  assign q1_eff  = (q1 == 4'd0) ? 4'd1 : q1;
  assign iod_eff = (iod == 4'd0) ? 4'd1 : iod;

  always_ff @(posedge clk) begin
    if (rst) begin
      q0 <= 4'd2;
      q1 <= 4'd4;
      iod <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_Q0:  q0 <= cfg_data;
        REG_Q1:  q1 <= cfg_data;
        REG_IO:  iod <= cfg_data;
        default: ;
      endcase
    end
  end

  // Level-0 FIFO is a circular buffer in memory, read in order from the head
  // pointer.
  logic [PW-1:0] l0_head;
  logic [CW-1:0] l0_count;
  logic [3:0]    l0_used;
  logic [CW-1:0] g_count [PRIORITY_LEVELS];
  logic [PW-1:0] g_head  [PRIORITY_LEVELS];
  logic [CW-1:0] b_count;

  // Latched item.
  logic       cmd_r;
  logic [3:0] pid_r;
  logic [2:0] prio_r;
  logic [1:0] oc_r;

  state_t state, state_next;

  // Walk indexes: rd_i reads, wr_i is the compacted write position.
  logic [CW-1:0] rd_i, wr_i;
  logic          walk_rd;  // a read was issued last cycle
  logic [GW-1:0] scan_g;
  logic          from_l1;
  logic [GW-1:0] run_g;
  logic [3:0]    run_id;
  logic [3:0]    run_rem;

  // Memories.
  logic          l0_we;
  logic [PW-1:0] l0_wa, l0_ra;
  logic [3:0]    l0_wd, l0_rd;
  logic          l1_we;
  logic [L1W-1:0] l1_wa, l1_ra;
  logic [7:0]    l1_wd, l1_rd;
  logic          b_we;
  logic [PW-1:0] b_wa, b_ra;
  logic [7:0]    b_wd, b_rd;
  logic          p_we;
  logic [3:0]    p_rd;

  mlfq_ram #(.WIDTH(4), .DEPTH(MAX_PROCS)) u_l0 (
    .clk(clk), .we(l0_we), .waddr(l0_wa), .wdata(l0_wd), .raddr(l0_ra), .rdata(l0_rd));
  mlfq_ram #(.WIDTH(8), .DEPTH(L1D)) u_l1 (
    .clk(clk), .we(l1_we), .waddr(l1_wa), .wdata(l1_wd), .raddr(l1_ra), .rdata(l1_rd));
  mlfq_ram #(.WIDTH(8), .DEPTH(MAX_PROCS)) u_blk (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  // Priority table, indexed by the 4-bit process id.
  logic [GW-1:0] prio_sat;
  assign prio_sat = (32'(prio_r) >= PRIORITY_LEVELS) ? GMAX : GW'(prio_r);
  mlfq_ram #(.WIDTH(4), .DEPTH(16)) u_pri (
    .clk(clk), .we(p_we), .waddr(pid_r), .wdata(4'(prio_sat)), .raddr(run_id),
    .rdata(p_rd));

  // The head is below MAX_PROCS and the offset at most MAX_PROCS, so one
  // conditional subtract wraps the sum.
  function automatic logic [PW-1:0] slot(input logic [PW-1:0] h, input logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(n);
    if (s >= (CW+1)'(MAX_PROCS)) s = s - (CW+1)'(MAX_PROCS);
    return PW'(s);
  endfunction

  // Level-0 tail push happens in several places; only one per cycle.
  logic [CW-1:0] l0_count_w;  // count that the admit decision sees
  logic          walk_pop;
  logic [3:0]    walk_rem;
  assign walk_rem = (b_rd[3:0] > 4'd0) ? b_rd[3:0] - 4'd1 : 4'd0;
  assign walk_pop = (state == ST_WALK) && walk_rd && (walk_rem == 4'd0);

  // Outcome decode for the running process.
  logic is_fin, is_blk;
  assign is_fin = (oc_r == OUT_FIN);
  assign is_blk = (oc_r == OUT_BLOCK);
  logic [3:0] used_inc;
  assign used_inc = l0_used + 4'd1;
  logic demote;
  assign demote = !from_l1 && !is_fin && !is_blk && (used_inc >= q0_eff);
  logic rotate;
  assign rotate = from_l1 && !is_fin && !is_blk && (run_rem <= 4'd1);

  // l0_used is already updated in ST_PUSH, so the demotion decided in
  // ST_EXEC is held in dem_r.
  logic dem_r, ran_r;
  logic demote_p;
  assign demote_p = dem_r;

  logic [GW-1:0] dem_g;
  assign dem_g = (32'(p_rd) >= PRIORITY_LEVELS) ? GMAX : GW'(p_rd);
  logic [GW-1:0] push_g;
  assign push_g = from_l1 ? run_g : dem_g;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = (command == CMD_ADMIT) ? ST_DONE : ST_WALK;
      ST_WALK: if (!walk_rd && rd_i >= b_count) state_next = ST_PICK;
      ST_PICK: begin
        if (l0_count != '0) state_next = ST_READ;
        else if (g_count[scan_g] != '0) state_next = ST_READ;
        else if (scan_g == '0) state_next = ST_DONE;
      end
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: state_next = ST_PUSH;
      ST_PUSH: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory ports.
  always_comb begin
    l0_we = 1'b0;
    l0_wa = slot(l0_head, l0_count);
    l0_wd = pid_r;
    l0_ra = l0_head;
    l1_we = 1'b0;
    l1_wa = '0;
    l1_wd = '0;
    l1_ra = L1W'(32'(scan_g) * MAX_PROCS + 32'(g_head[scan_g]));
    b_we = 1'b0;
    b_wa = PW'(wr_i);
    b_wd = {b_rd[7:4], walk_rem};
    b_ra = PW'(rd_i);
    p_we = 1'b0;
    unique case (state)
      ST_DONE: if (cmd_r == CMD_ADMIT && l0_count < FULL) begin
        l0_we = 1'b1;
        p_we = 1'b1;
      end
      ST_WALK: if (walk_rd) begin
        if (walk_pop) begin
          l0_we = (l0_count < FULL);
          l0_wd = b_rd[7:4];
        end else begin
          b_we = 1'b1;
        end
      end
      ST_EXEC: if (from_l1 && !is_fin && !is_blk && !rotate) begin
        l1_we = 1'b1;
        l1_wa = L1W'(32'(run_g) * MAX_PROCS + 32'(g_head[run_g]));
        l1_wd = {run_id, run_rem - 4'd1};
      end
      ST_PUSH: begin
        if (is_blk && b_count < FULL) begin
          b_we = 1'b1;
          b_wa = PW'(b_count);
          b_wd = {run_id, iod_eff};
        end else if ((demote_p || rotate) && g_count[push_g] < FULL) begin
          l1_we = 1'b1;
          l1_wa = L1W'(32'(push_g) * MAX_PROCS
                       + 32'(slot(g_head[push_g], g_count[push_g])));
          l1_wd = {run_id, q1_eff};
        end
      end
      default: ;
    endcase
  end
  assign l0_count_w = l0_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      l0_head <= '0;
      l0_count <= '0;
      l0_used <= '0;
      b_count <= '0;
      walk_rd <= 1'b0;
      for (int g = 0; g < PRIORITY_LEVELS; g++) begin
        g_count[g] <= '0;
        g_head[g] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (start) begin
          rd_i <= '0;
          wr_i <= '0;
          walk_rd <= 1'b0;
        end
        ST_WALK: begin
          if (walk_rd) begin
            if (walk_pop) begin
              if (l0_count < FULL) l0_count <= l0_count + 1'b1;
            end else begin
              wr_i <= wr_i + 1'b1;
            end
          end
          if (rd_i < b_count) begin
            rd_i <= rd_i + 1'b1;
            walk_rd <= 1'b1;
          end else begin
            walk_rd <= 1'b0;
            if (!walk_rd) b_count <= wr_i;
          end
          scan_g <= GMAX;
        end
        ST_PICK: begin
          from_l1 <= (l0_count == '0);
          run_g <= scan_g;
          if (l0_count == '0 && g_count[scan_g] == '0 && scan_g != '0)
            scan_g <= scan_g - 1'b1;
        end
        ST_READ: begin
          run_id <= from_l1 ? l1_rd[7:4] : l0_rd;
          run_rem <= l1_rd[3:0];
        end
        ST_EXEC: begin
          if (!from_l1) begin
            l0_used <= (is_fin || is_blk || demote) ? 4'd0 : used_inc;
            if (is_fin || is_blk || demote) begin
              l0_head <= slot(l0_head, CW'(1));
              l0_count <= l0_count - 1'b1;
            end
          end else if (is_fin || is_blk || rotate) begin
            g_head[run_g] <= slot(g_head[run_g], CW'(1));
            g_count[run_g] <= g_count[run_g] - 1'b1;
          end
        end
        ST_PUSH: begin
          if (is_blk) begin
            if (b_count < FULL) b_count <= b_count + 1'b1;
          end else if ((demote_p || rotate) && g_count[push_g] < FULL) begin
            g_count[push_g] <= g_count[push_g] + 1'b1;
          end
        end
        ST_DONE: if (cmd_r == CMD_ADMIT && l0_count < FULL) begin
          l0_count <= l0_count + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd_r <= command;
      pid_r <= proc_id;
      prio_r <= priority_req;
      oc_r <= outcome;
      ran_r <= 1'b0;
      dem_r <= 1'b0;
    end
    if (state == ST_READ) ran_r <= 1'b1;
    if (state == ST_EXEC) dem_r <= demote;
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
    end
    ran_valid <= (cmd_r == CMD_TICK) && ran_r;
    ran_id <= ((cmd_r == CMD_TICK) && ran_r) ? run_id : 4'd0;
    ran_finished <= (cmd_r == CMD_TICK) && ran_r && is_fin;
    ran_blocked <= (cmd_r == CMD_TICK) && ran_r && is_blk;
    ran_demoted <= (cmd_r == CMD_TICK) && ran_r && demote_p;
    admit_refused <= (cmd_r == CMD_ADMIT) && (l0_count_w >= FULL);
  end
endmodule
`default_nettype wire

FILE: hw/rtl/mlfq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
